// ----- src/adtg_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-128 dynamic tag generator package
// Shared types, register indexes, the AES S-box and round helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package adtg_pkg;

    localparam int NumRounds = 10;

    typedef logic [127:0] block_t;
    typedef logic [7:0]   byte_t;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

    function automatic byte_t sbox(input byte_t x);
        byte_t r;
        r = 8'h00;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte k of the block sits in bits 127-8k downto 120-8k.
    function automatic byte_t get_byte(input block_t b, input int k);
        return b[127 - 8 * k -: 8];
    endfunction

    // One round key step of the AES-128 schedule.
    function automatic block_t next_key(input block_t rk, input byte_t rcon);
        block_t o;
        byte_t  t0, t1, t2, t3;
        t0 = sbox(get_byte(rk, 13)) ^ rcon;
        t1 = sbox(get_byte(rk, 14));
        t2 = sbox(get_byte(rk, 15));
        t3 = sbox(get_byte(rk, 12));
        o[127:96] = rk[127:96] ^ {t0, t1, t2, t3};
        o[95:64]  = rk[95:64] ^ o[127:96];
        o[63:32]  = rk[63:32] ^ o[95:64];
        o[31:0]   = rk[31:0] ^ o[63:32];
        return o;
    endfunction

    // SubBytes, ShiftRows, optional MixColumns, then AddRoundKey.
    function automatic block_t enc_round(input block_t s, input block_t rk,
                                         input logic last);
        block_t t, m;
        byte_t  a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (i + 4 * c) -: 8] = sbox(get_byte(s, i + 4 * ((c + i) % 4)));
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(t, 4 * c);
            a1 = get_byte(t, 4 * c + 1);
            a2 = get_byte(t, 4 * c + 2);
            a3 = get_byte(t, 4 * c + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            m[127 - 32 * c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                     a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
        end
        return (last ? t : m) ^ rk;
    endfunction

endpackage

`default_nettype wire

// ----- src/aes128_dynamic_tag_generator.sv -----
// ----------------------------------------------------------------------------
// AES-128 dynamic tag generator
// Encrypts a block built from an address and expiry time; returns a 56-bit tag.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_axis   in         tdata[47:0] adv_address, tdata[79:48] expiry_time
//  m_axis   out        tdata[55:0] tag
//  cfg      in         index 0 key_high, index 1 key_low, 64-bit data
//
// The datapath is eleven register stages: the initial key addition, then one
// stage per AES round. A beat passes through the key-addition register and
// then each round register in turn, the last being the output register.
// One beat is accepted every cycle unless stalled. A single stall signal freezes
// the whole pipe when the output beat is held, so nothing is lost or repeated.
// Reset clears the key registers and all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_dynamic_tag_generator
    import adtg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // adv_address, expiry_time
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // tag
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam logic [7:0] RconTab [NumRounds] = '{8'h01, 8'h02, 8'h04, 8'h08,
        8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        enable;
    block_t      pt;
    block_t      key;
    logic        v_reg;
    block_t      s_reg;
    block_t      k_reg;
    logic   [NumRounds:0] vv;
    block_t [NumRounds:0] ss;
    block_t [NumRounds:0] kk;

    // The pipe advances whenever the last stage is empty or being drained.
    assign enable        = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = enable;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Plaintext: six zero bytes, address, then big-endian expiry.
    assign pt  = {48'h0, s_axis_tdata[47:0], s_axis_tdata[79:48]};
    assign key = {key_high_reg, key_low_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end
        else if (enable) begin
            v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk) begin
        if (enable) begin
            s_reg <= pt ^ key;
            k_reg <= key;
        end
    end

    assign vv[0] = v_reg;
    assign ss[0] = s_reg;
    assign kk[0] = k_reg;

    for (genvar r = 0; r < NumRounds; r++) begin : g_round
        adtg_round #(
            .RCON (RconTab[r]),
            .LAST (r == NumRounds - 1)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .enable    (enable),
            .valid_in  (vv[r]),
            .state_in  (ss[r]),
            .key_in    (kk[r]),
            .valid_out (vv[r + 1]),
            .state_out (ss[r + 1]),
            .key_out   (kk[r + 1])
        );
    end

    assign m_axis_tvalid = vv[NumRounds];
    assign m_axis_tdata  = ss[NumRounds][127:72];

endmodule

`default_nettype wire

// ----- src/adtg_round.sv -----
// ----------------------------------------------------------------------------
// AES round stage
// One cipher round and the matching key step, registered, with stall.
// ----------------------------------------------------------------------------
`default_nettype none

module adtg_round
    import adtg_pkg::*;
#(
    parameter logic [7:0] RCON = 8'h01,
    parameter bit         LAST = 1'b0
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   enable,
    input  wire logic   valid_in,
    input  wire block_t state_in,
    input  wire block_t key_in,
    output logic        valid_out,
    output block_t      state_out,
    output block_t      key_out
);

    block_t key_next;
    block_t state_next;
    logic   valid_reg;
    block_t state_reg;
    block_t key_reg;

    assign key_next   = next_key(key_in, RCON);
    assign state_next = enc_round(state_in, key_next, LAST);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (enable) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk) begin
        if (enable) begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;

endmodule

`default_nettype wire
